// ===== hdl/rotdec_pkg.sv =====
package rotdec_pkg;

  // Level vector layout: bit 0 button, bit 1 first line, bit 2 second line
  localparam int LVL_W      = 3;
  localparam int BIT_BUTTON = 0;
  localparam int BIT_CLOCK  = 1;
  localparam int BIT_ANTI   = 2;

  localparam int QT_W = 16;
  localparam logic [QT_W-1:0] QT_RESET = 16'd2;

  // event queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [1:0] ev_code_t;

  localparam ev_code_t EV_RELEASED = 2'd0;
  localparam ev_code_t EV_PRESSED  = 2'd1;
  localparam ev_code_t EV_FORWARD  = 2'd2;
  localparam ev_code_t EV_BACKWARD = 2'd3;

  // one settle: one or two events, first always valid when queued
  typedef struct packed {
    logic     two;
    ev_code_t first;
    ev_code_t second;
  } ev_pair_t;

endpackage

// ===== hdl/rotdec_if.sv =====
interface rotdec_in_if;
  logic valid;
  logic ready;
  logic button_level;
  logic clock_level;
  logic anti_level;

  modport source (output valid, output button_level, output clock_level,
                  output anti_level, input ready);
  modport sink   (input valid, input button_level, input clock_level,
                  input anti_level, output ready);
endinterface

interface rotdec_out_if import rotdec_pkg::*; ();
  logic     valid;
  logic     ready;
  ev_code_t event_code;
  logic     last_event;

  modport source (output valid, output event_code, output last_event, input ready);
  modport sink   (input valid, input event_code, input last_event, output ready);
endinterface

interface rotdec_cfg_if import rotdec_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [QT_W-1:0] quiet_ticks;

  modport source (output valid, output quiet_ticks, input ready);
  modport sink   (input valid, input quiet_ticks, output ready);
endinterface

// ===== hdl/rotdec_front.sv =====
module rotdec_front import rotdec_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  rotdec_in_if.sink       in_ch,
  rotdec_cfg_if.sink      cfg_ch,
  input  logic            q_full,
  output logic            push,
  output ev_pair_t        push_data
);

  logic [QT_W-1:0]  quiet_ticks_r, quiet_ticks_nxt;
  logic [LVL_W-1:0] raw_r, raw_nxt;
  logic [LVL_W-1:0] settled_r, settled_nxt;
  logic [QT_W-1:0]  quiet_count_r, quiet_count_nxt;
  logic             pending_r, pending_nxt;

  logic [LVL_W-1:0] levels_now;
  logic [QT_W-1:0]  cnt_inc;
  logic             accept;
  logic             settle;
  logic             btn_ev;
  logic             turn_ev;
  ev_code_t         btn_code;
  ev_code_t         turn_code;

  assign in_ch.ready  = ~q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid & in_ch.ready;
  assign levels_now   = {in_ch.anti_level, in_ch.clock_level, in_ch.button_level};

  // saturating quiet counter; a setting of zero acts as one
  assign cnt_inc = (quiet_count_r == '1) ? quiet_count_r : quiet_count_r + 1'b1;
  assign settle  = accept & (levels_now == raw_r) & pending_r & (cnt_inc >= quiet_ticks_r);

  assign btn_ev    = raw_r[BIT_BUTTON] ^ settled_r[BIT_BUTTON];
  assign turn_ev   = (raw_r[BIT_CLOCK] ^ settled_r[BIT_CLOCK]) & ~raw_r[BIT_CLOCK];
  assign btn_code  = raw_r[BIT_BUTTON] ? EV_RELEASED : EV_PRESSED;
  assign turn_code = raw_r[BIT_ANTI] ? EV_BACKWARD : EV_FORWARD;

  assign push             = settle & (btn_ev | turn_ev);
  assign push_data.two    = btn_ev & turn_ev;
  assign push_data.first  = btn_ev ? btn_code : turn_code;
  assign push_data.second = turn_code;

  always_comb begin
    quiet_ticks_nxt = quiet_ticks_r;
    raw_nxt         = raw_r;
    settled_nxt     = settled_r;
    quiet_count_nxt = quiet_count_r;
    pending_nxt     = pending_r;
    if (cfg_ch.valid) begin
      quiet_ticks_nxt = cfg_ch.quiet_ticks;
    end
    if (accept) begin
      if (levels_now != raw_r) begin
        raw_nxt         = levels_now;
        quiet_count_nxt = '0;
        pending_nxt     = 1'b1;
      end else if (settle) begin
        settled_nxt     = raw_r;
        quiet_count_nxt = '0;
        pending_nxt     = 1'b0;
      end else if (pending_r) begin
        quiet_count_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_ticks_r <= QT_RESET;
      raw_r         <= '1;
      settled_r     <= '1;
      quiet_count_r <= '0;
      pending_r     <= 1'b0;
    end else begin
      quiet_ticks_r <= quiet_ticks_nxt;
      raw_r         <= raw_nxt;
      settled_r     <= settled_nxt;
      quiet_count_r <= quiet_count_nxt;
      pending_r     <= pending_nxt;
    end
  end

  // timer only runs while a change waits
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> quiet_count_r == '0)
    else $error("quiet counter running with nothing pending");

endmodule

// ===== hdl/rotdec_queue.sv =====
module rotdec_queue import rotdec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ev_pair_t push_data,
  input  logic     pop,
  output ev_pair_t head,
  output logic     full,
  output logic     empty
);

  ev_pair_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("event queue underflow");

endmodule

// ===== hdl/rotdec_back.sv =====
module rotdec_back import rotdec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  ev_pair_t    q_head,
  output logic        pop,
  rotdec_out_if.source out_ch
);

  logic     out_valid_r, out_valid_nxt;
  ev_code_t out_code_r, out_code_nxt;
  logic     out_last_r, out_last_nxt;
  logic     second_r, second_nxt;   // head's second event still to go
  logic     load;

  assign load              = ~out_valid_r | out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_code_r;
  assign out_ch.last_event = out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    second_nxt    = second_r;
    pop           = 1'b0;
    if (load) begin
      if (second_r) begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = q_head.second;
        out_last_nxt  = 1'b1;
        second_nxt    = 1'b0;
        pop           = 1'b1;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = q_head.first;
        out_last_nxt  = ~q_head.two;
        second_nxt    = q_head.two;
        pop           = ~q_head.two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> !q_empty)
    else $error("second event pending without queue entry");

  a_second_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> out_valid_r && !out_last_r)
    else $error("first of a pair marked as last");

endmodule

// ===== hdl/rotary_encoder_debounce_decoder_unit.sv =====
// Channel  Dir  Payload                                   Transfer
// in_ch    in   button_level, clock_level, anti_level     valid & ready
// out_ch   out  event_code[1:0], last_event               valid & ready
// cfg_ch   in   quiet_ticks[15:0]                         valid & ready (always ready)
//
// One input transfer per cycle while the event queue has room; most ticks give no event.
// A settle emits one or two events, one output transfer per cycle while out_ch is ready.
// Queue of two settles decouples sampling from a stalled consumer; in_ch.ready drops only
// when it is full. Output is registered; a stall holds it without blocking the front.
// Synchronous active-low reset: levels all high, timer clear, quiet_ticks back to 2.
module rotary_encoder_debounce_decoder_unit import rotdec_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rotdec_in_if.sink    in_ch,
  rotdec_cfg_if.sink   cfg_ch,
  rotdec_out_if.source out_ch
);

  // front -> queue
  logic     push;
  ev_pair_t push_data;
  // queue -> back
  logic     pop;
  ev_pair_t q_head;
  logic     q_full;
  logic     q_empty;

  // Front: debounce timer and settle classification; queues only settles that emit.
  rotdec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Short queue of event pairs between the two halves.
  rotdec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: splits each pair into single events, tags the last one of a tick.
  rotdec_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/tb_rotary_encoder_debounce_decoder_unit.sv =====
module tb_rotary_encoder_debounce_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rotdec_pkg::*;

  // No transfer on any channel for this many cycles means the block is stuck.
  // The slowest correct run: a sender gap or a consumer stall of the longest
  // pick_len stretch, a drain plus SETTLE_CYCLES quiet cycles before a register write.
  localparam int STUCK_LIMIT = 2000;
  // Quiet cycles after the last event before a register write or the end.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  // Quiet timer saturation value.
  localparam logic [QT_W-1:0] QT_MAX = '1;
  // Ticks held at the largest setting, far short of settling.
  localparam int LONG_HOLD = 20;
  // Row count meaning "work the result out with the predictor".
  localparam int PREDICTED = -1;

  // One sample tick of stimulus. Level layout as in the package:
  // bit 0 button, bit 1 first line, bit 2 second line.
  typedef struct {
    logic [LVL_W-1:0] lv;
    int               n;   // typed result count, or PREDICTED
    ev_code_t         e0;
    ev_code_t         e1;
  } stim_row_t;

  typedef struct {
    ev_code_t code;
    logic     last;
  } event_rec_t;

  logic clk;
  logic rst_n;

  rotdec_in_if  in_if();
  rotdec_out_if out_if();
  rotdec_cfg_if cfg_if();

  rotary_encoder_debounce_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  // Row travelling with the current input item, so the checker knows whether
  // the expected events are typed in or predicted.
  stim_row_t cur_row;

  // Debounce predictor state and its copy of the quiet_ticks register.
  logic [LVL_W-1:0] seen_levels;
  logic [LVL_W-1:0] stable_levels;
  logic [QT_W-1:0]  quiet_run;
  logic             change_waiting;
  logic [QT_W-1:0]  quiet_setting;

  // Events still owed by the block, oldest first.
  event_rec_t awaited_events[$];
  int errors;

  // Idle pacing: when calm, that side never idles.
  bit tx_calm;
  bit rx_calm;

  stim_row_t directed_rows[24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short stretches, now and then a long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic void debounce_reset();
    seen_levels    = '1;
    stable_levels  = '1;
    quiet_run      = '0;
    change_waiting = 1'b0;
    quiet_setting  = QT_RESET;
  endfunction

  // One sample tick through the debouncer; returns the events it emits.
  function automatic void debounce_tick(input logic [LVL_W-1:0] now, output int n,
                                        output ev_code_t evs[2]);
    n = 0;
    evs[0] = EV_RELEASED;
    evs[1] = EV_RELEASED;
    // any raw change restarts the quiet timer
    if (now != seen_levels) begin
      seen_levels    = now;
      quiet_run      = '0;
      change_waiting = 1'b1;
      return;
    end
    if (!change_waiting) return;
    if (quiet_run != QT_MAX) quiet_run++;
    // a setting of zero settles on the first unchanged tick, like one
    if (quiet_run < quiet_setting) return;

    if (seen_levels[BIT_BUTTON] != stable_levels[BIT_BUTTON]) begin
      evs[n] = seen_levels[BIT_BUTTON] ? EV_RELEASED : EV_PRESSED;
      n++;
    end
    // second line is taken over before the first line's edge is judged
    stable_levels[BIT_ANTI] = seen_levels[BIT_ANTI];
    if (stable_levels[BIT_CLOCK] && !seen_levels[BIT_CLOCK]) begin
      evs[n] = stable_levels[BIT_ANTI] ? EV_BACKWARD : EV_FORWARD;
      n++;
    end
    stable_levels  = seen_levels;
    quiet_run      = '0;
    change_waiting = 1'b0;
  endfunction

  // Consumer side: random stalls, with calm stretches where ready stays high.
  initial begin
    int stall;
    stall = 0;
    rx_calm = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(399) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!rx_calm && $urandom_range(99) < 25) stall = pick_len();
      end
    end
  end

  // Checker and predictor. Outputs are checked before the new input is
  // predicted: an event seen at this edge always belongs to an older tick.
  always @(posedge clk) begin
    event_rec_t want;
    int         n;
    ev_code_t   evs[2];
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_events.size() == 0) begin
          $error("event_code: expected no event, got %0d (last_event %0b)",
                 out_if.event_code, out_if.last_event);
          errors++;
        end else begin
          want = awaited_events.pop_front();
          if (out_if.event_code !== want.code) begin
            $error("event_code: expected %0d, got %0d", want.code, out_if.event_code);
            errors++;
          end
          if (out_if.last_event !== want.last) begin
            $error("last_event: expected %0b, got %0b", want.last, out_if.last_event);
            errors++;
          end
        end
      end

      if (in_if.valid && in_if.ready) begin
        debounce_tick({in_if.anti_level, in_if.clock_level, in_if.button_level}, n, evs);
        // typed rows override the predicted events, state still advances
        if (cur_row.n != PREDICTED) begin
          n = cur_row.n;
          evs[0] = cur_row.e0;
          evs[1] = cur_row.e1;
        end
        for (int i = 0; i < n; i++) awaited_events.push_back('{evs[i], i == n - 1});
      end

      if (cfg_if.valid && cfg_if.ready) quiet_setting = cfg_if.quiet_ticks;
    end
  end

  // Watchdog on transfers of any kind.
  always @(posedge clk) begin
    int stuck;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One input transfer, with an optional gap in front of it.
  task automatic send_row(input stim_row_t row);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(99) < 30) gap = pick_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.button_level <= row.lv[BIT_BUTTON];
    in_if.clock_level  <= row.lv[BIT_CLOCK];
    in_if.anti_level   <= row.lv[BIT_ANTI];
    cur_row            <= row;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_levels(input logic [LVL_W-1:0] lv);
    send_row('{lv, PREDICTED, EV_RELEASED, EV_RELEASED});
  endtask

  // Stop sending and wait for every owed event; sampled on the falling edge
  // so the checker's updates at the rising edge are already in. Returns on a
  // rising edge so the next drive lands there.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (awaited_events.size() != 0);
    @(posedge clk);
  endtask

  // Register write only with the block idle; a settle with no events may
  // still be in flight, hence the extra quiet cycles.
  task automatic write_quiet(input logic [QT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.quiet_ticks <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Random ticks shaped as debounce episodes: mostly a change held long
  // enough to settle (sometimes after contact bounce), some changes that
  // revert too early, and some plain noise.
  task automatic run_random(input int quota);
    int done;
    int r;
    int qe;
    int hold;
    logic [LVL_W-1:0] target;
    done = 0;
    qe = (quiet_setting == 0) ? 1 : int'(quiet_setting);
    while (done < quota) begin
      if ($urandom_range(99) < 3) tx_calm = !tx_calm;
      if ($urandom_range(99) < 2) wait_drained();
      r = $urandom_range(99);
      target = LVL_W'($urandom_range(7));
      if (r < 70) begin
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 3)) begin
            send_levels(LVL_W'($urandom_range(7)));
            done++;
          end
        end
        repeat (1 + qe) begin
          send_levels(target);
          done++;
        end
        // a few idle ticks after the settle
        repeat ($urandom_range(0, 2)) begin
          send_levels(target);
          done++;
        end
      end else if (r < 85) begin
        // held too briefly to settle
        repeat (1 + $urandom_range(0, qe - 1)) begin
          send_levels(target);
          done++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_levels(LVL_W'($urandom_range(7)));
          done++;
        end
      end
    end
  endtask

  initial begin
    logic [LVL_W-1:0] lv;
    errors  = 0;
    tx_calm = 1'b0;
    debounce_reset();
    cur_row = '{'1, PREDICTED, EV_RELEASED, EV_RELEASED};

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.button_level <= 1'b1;
    in_if.clock_level  <= 1'b1;
    in_if.anti_level   <= 1'b1;
    cfg_if.valid       <= 1'b0;
    cfg_if.quiet_ticks <= '0;

    // Level rows as {second line, first line, button}, quiet_ticks at reset (2).
    directed_rows = '{
      '{3'b111, 0,         EV_RELEASED, EV_RELEASED},  // idle after reset, nothing pending
      '{3'b110, PREDICTED, EV_RELEASED, EV_RELEASED},  // press
      '{3'b110, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b110, 1,         EV_PRESSED,  EV_RELEASED},  // settles
      '{3'b000, PREDICTED, EV_RELEASED, EV_RELEASED},  // first line falls, second low
      '{3'b000, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b000, 1,         EV_FORWARD,  EV_RELEASED},
      '{3'b011, PREDICTED, EV_RELEASED, EV_RELEASED},  // release and rising first line
      '{3'b011, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b011, 1,         EV_RELEASED, EV_RELEASED},  // rising edge gives nothing
      '{3'b100, PREDICTED, EV_RELEASED, EV_RELEASED},  // press, fall, second high
      '{3'b100, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b100, 2,         EV_PRESSED,  EV_BACKWARD},  // both events from one settle
      '{3'b101, PREDICTED, EV_RELEASED, EV_RELEASED},  // bounce ...
      '{3'b100, PREDICTED, EV_RELEASED, EV_RELEASED},  // ... reverted before settling
      '{3'b100, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b100, 0,         EV_RELEASED, EV_RELEASED},  // settles with no difference
      '{3'b111, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b111, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b111, 1,         EV_RELEASED, EV_RELEASED},
      '{3'b111, 0,         EV_RELEASED, EV_RELEASED},  // nothing pending
      '{3'b001, PREDICTED, EV_RELEASED, EV_RELEASED},  // both lines fall together
      '{3'b001, PREDICTED, EV_RELEASED, EV_RELEASED},
      '{3'b001, 1,         EV_FORWARD,  EV_RELEASED}   // second line taken over first
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    run_random(400);
    write_quiet(16'd1);
    run_random(300);
    write_quiet(16'd0);
    run_random(250);
    write_quiet(16'd3);
    run_random(300);
    write_quiet(QT_W'($urandom_range(4, 9)));
    run_random(300);

    // Largest setting: a button change held, far short of settling.
    write_quiet(QT_MAX);
    tx_calm = 1'b1;
    lv = seen_levels ^ (LVL_W'(1) << BIT_BUTTON);
    repeat (LONG_HOLD) send_levels(lv);
    tx_calm = 1'b0;

    write_quiet(QT_RESET);
    run_random(200);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_events.size() != 0) begin
      $error("event_code: %0d events still expected at the end", awaited_events.size());
      errors++;
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
